FILE: sv/lcg_pkg.sv
// Package for the LCG block: widths, item types and the divider handshake structs.
// No dependencies; every other file of the block imports it.
package lcg_pkg;

	// value width and modulus width (the modulus may reach 2^VAL_W)
	localparam int VAL_W = 32;
	localparam int MOD_W = VAL_W + 1;
	// trial divisor width: p never exceeds sqrt(2^MOD_W) + 1
	localparam int P_W = (MOD_W + 1) / 2 + 1;
	// divider step counter width
	localparam int DIV_CNT_W = $clog2(MOD_W + 1);

	localparam logic [VAL_W-1:0] MAX_VALUE_RST = VAL_W'(255);

	localparam logic KIND_RESTART = 1'b0;
	localparam logic KIND_NEXT    = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [VAL_W-1:0] seed;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [VAL_W-1:0] multiplier;
		logic             full_period;
	} out_item_t;

	typedef struct packed {
		logic             start;
		logic [MOD_W-1:0] num;
		logic [MOD_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [MOD_W-1:0] quo;
		logic [MOD_W-1:0] rem;
	} div_rsp_t;

endpackage

FILE: sv/lcg_div.sv
// Restoring divider, one quotient bit per cycle, giving an MOD_W-bit quotient and remainder.
// Depends on lcg_pkg for widths and the request/response structs.
module lcg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lcg_pkg::div_req_t req,
	output lcg_pkg::div_rsp_t rsp
);
	import lcg_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [MOD_W-1:0]     quo_q;
	logic [MOD_W-1:0]     rem_q;
	logic [MOD_W-1:0]     den_q;

	logic [MOD_W:0] rem_sh;
	logic [MOD_W:0] diff;
	logic           ge;

	assign rem_sh = {rem_q, quo_q[MOD_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign ge     = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(MOD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift in one numerator bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[MOD_W-2:0], ge};
			rem_q <= ge ? diff[MOD_W-1:0] : rem_sh[MOD_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

FILE: sv/lcg_with_hull_dobell_params.sv
// Top level of the LCG with Hull-Dobell multiplier derivation: sequencer and datapath.
// Depends on lcg_pkg and instantiates lcg_div, the shared divider.
//
// Usage
//   Input channel in_valid/in_stall/in_item: kind selects restart (load seed, derive
//   the multiplier for m = max_value + 1) or next (x = (a*x + 1) mod m).
//   Output channel out_valid/out_stall/out_item: one item per input item, carrying
//   the new value, the multiplier in use and the full-period flag.
//   cfg_we/cfg_data write max_value; write it only while the block is idle.
// Sequencing
//   One item at a time; in_stall is high from acceptance until the result is loaded.
//   Next item: a divider reduction when x is not below m, then a shift-add modular
//   multiply, one step per significant multiplier bit, then the increment is added
//   and the output is loaded. Restart: trial division by p = 2, 3, ... up to sqrt(m),
//   each step one divider pass plus a short shift-add multiply per prime found; a gcd
//   search follows when the Hull-Dobell multiplier does not fit below m and m > 2.
// Reset: value 0, multiplier 1, full_period 0, max_value 255, no item pending.
// Stall: a finished item waits in the output register; the block still accepts a
//   new item, but holds its next result until the register is free.
module lcg_with_hull_dobell_params (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [lcg_pkg::VAL_W-1:0] cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  lcg_pkg::in_item_t       in_item,
	output logic                    out_valid,
	input  logic                    out_stall,
	output lcg_pkg::out_item_t      out_item
);
	import lcg_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_XRED = 7'b0000010,
		S_MUL  = 7'b0000100,
		S_TDIV = 7'b0001000,
		S_RAD  = 7'b0010000,
		S_GCD  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	// architectural state
	logic [VAL_W-1:0] max_q;
	logic [VAL_W-1:0] cur_q;
	logic [VAL_W-1:0] mult_q;
	logic             fp_q;

	// derivation registers
	logic [MOD_W-1:0] rest_q;
	logic [MOD_W-1:0] rad_q;
	logic [P_W-1:0]   p_q;
	logic             strip_q;  // dividing out a prime already found
	logic             fin_q;    // multiply is the final rad * rest
	logic [MOD_W-1:0] ga_q;     // fallback candidate
	logic [MOD_W-1:0] gy_q;     // Euclid divisor

	// shift-add multiply
	logic [MOD_W-1:0] acc_q;
	logic [MOD_W-1:0] mc_q;
	logic [MOD_W-1:0] mp_q;
	logic             mmod_q;   // reduce modulo m (next item) or plain product

	// divider request
	logic             div_go_q;
	logic [MOD_W-1:0] div_num_q;
	logic [MOD_W-1:0] div_den_q;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	// combinational helpers
	logic [MOD_W-1:0] mod_w;
	logic [MOD_W:0]   sum_acc;
	logic [MOD_W:0]   sum_mc;
	logic [MOD_W:0]   sum_fin;
	logic [MOD_W-1:0] acc_nx;
	logic [MOD_W-1:0] mc_nx;
	logic [MOD_W-1:0] fin_nx;
	logic [MOD_W:0]   radx;
	logic [MOD_W:0]   radp1;
	logic [P_W-1:0]   p_inc;
	logic [MOD_W-1:0] ga_inc;
	logic             accept;
	logic             out_free;

	assign mod_w    = {1'b0, max_q} + MOD_W'(1);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign p_inc    = p_q + P_W'(1);
	assign ga_inc   = ga_q + MOD_W'(1);

	// one shift-add step: conditional add of mc into acc, double mc (mod m when mmod_q); also acc + 1 mod m
	always_comb begin
		sum_acc = {1'b0, acc_q} + {1'b0, mc_q};
		sum_mc  = {mc_q, 1'b0};
		sum_fin = {1'b0, acc_q} + (MOD_W + 1)'(1);
		acc_nx  = acc_q;
		if (mp_q[0]) begin
			if (mmod_q && (sum_acc >= {1'b0, mod_w})) begin
				acc_nx = sum_acc[MOD_W-1:0] - mod_w;
			end else begin
				acc_nx = sum_acc[MOD_W-1:0];
			end
		end
		if (mmod_q && (sum_mc >= {1'b0, mod_w})) begin
			mc_nx = sum_mc[MOD_W-1:0] - mod_w;
		end else begin
			mc_nx = sum_mc[MOD_W-1:0];
		end
		if (sum_fin >= {1'b0, mod_w}) begin
			fin_nx = sum_fin[MOD_W-1:0] - mod_w;
		end else begin
			fin_nx = sum_fin[MOD_W-1:0];
		end
	end

	// radical of m, doubled when 4 divides m
	assign radx  = (mod_w[1:0] == 2'b00) ? {rad_q, 1'b0} : {1'b0, rad_q};
	assign radp1 = radx + (MOD_W + 1)'(1);

	assign div_req.start = div_go_q;
	assign div_req.num   = div_num_q;
	assign div_req.den   = div_den_q;

	lcg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_VALUE_RST;
		end else if (cfg_we) begin
			max_q <= cfg_data;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			mult_q      <= VAL_W'(1);
			fp_q        <= 1'b0;
			div_go_q    <= 1'b0;
			out_valid_q <= 1'b0;
			strip_q     <= 1'b0;
			fin_q       <= 1'b0;
			mmod_q      <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			// drop the output item once it is taken
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_item.kind == KIND_RESTART) begin
							cur_q     <= in_item.seed;
							rest_q    <= mod_w;
							rad_q     <= MOD_W'(1);
							p_q       <= P_W'(2);
							strip_q   <= 1'b0;
							div_go_q  <= 1'b1;
							div_num_q <= mod_w;
							div_den_q <= MOD_W'(2);
							state_q   <= S_TDIV;
						end else if ({1'b0, cur_q} >= mod_w) begin
							// reduce x below m first
							div_go_q  <= 1'b1;
							div_num_q <= {1'b0, cur_q};
							div_den_q <= mod_w;
							state_q   <= S_XRED;
						end else begin
							acc_q   <= '0;
							mc_q    <= {1'b0, cur_q};
							mp_q    <= {1'b0, mult_q};
							mmod_q  <= 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_XRED: begin
					if (div_rsp.done) begin
						acc_q   <= '0;
						mc_q    <= div_rsp.rem;
						mp_q    <= {1'b0, mult_q};
						mmod_q  <= 1'b1;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mp_q == '0) begin
						if (mmod_q) begin
							// add the increment and finish the next item
							cur_q   <= fin_nx[VAL_W-1:0];
							state_q <= S_DONE;
						end else begin
							rad_q <= acc_q;
							if (fin_q) begin
								state_q <= S_RAD;
							end else begin
								// strip the prime p out of rest
								strip_q   <= 1'b1;
								div_go_q  <= 1'b1;
								div_num_q <= rest_q;
								div_den_q <= MOD_W'(p_q);
								state_q   <= S_TDIV;
							end
						end
					end else begin
						acc_q <= acc_nx;
						mc_q  <= mc_nx;
						mp_q  <= {1'b0, mp_q[MOD_W-1:1]};
					end
				end
				S_TDIV: begin
					if (div_rsp.done) begin
						priority if (strip_q) begin
							if (div_rsp.rem == '0) begin
								rest_q    <= div_rsp.quo;
								div_go_q  <= 1'b1;
								div_num_q <= div_rsp.quo;
								div_den_q <= MOD_W'(p_q);
							end else begin
								strip_q   <= 1'b0;
								p_q       <= p_inc;
								div_go_q  <= 1'b1;
								div_num_q <= rest_q;
								div_den_q <= MOD_W'(p_inc);
							end
						end else if (MOD_W'(p_q) > div_rsp.quo) begin
							// p past sqrt(rest): what is left is prime or one
							if (rest_q > MOD_W'(1)) begin
								acc_q   <= '0;
								mc_q    <= rad_q;
								mp_q    <= rest_q;
								mmod_q  <= 1'b0;
								fin_q   <= 1'b1;
								state_q <= S_MUL;
							end else begin
								state_q <= S_RAD;
							end
						end else if (div_rsp.rem == '0) begin
							rest_q  <= div_rsp.quo;
							acc_q   <= '0;
							mc_q    <= rad_q;
							mp_q    <= MOD_W'(p_q);
							mmod_q  <= 1'b0;
							fin_q   <= 1'b0;
							state_q <= S_MUL;
						end else begin
							p_q       <= p_inc;
							div_go_q  <= 1'b1;
							div_num_q <= rest_q;
							div_den_q <= MOD_W'(p_inc);
						end
					end
				end
				S_RAD: begin
					if (radp1 < {1'b0, mod_w}) begin
						mult_q  <= radp1[VAL_W-1:0];
						fp_q    <= 1'b1;
						state_q <= S_DONE;
					end else begin
						fp_q <= 1'b0;
						if (mod_w > MOD_W'(2)) begin
							// search the smallest a >= 2 coprime with m
							ga_q      <= MOD_W'(2);
							gy_q      <= MOD_W'(2);
							div_go_q  <= 1'b1;
							div_num_q <= mod_w;
							div_den_q <= MOD_W'(2);
							state_q   <= S_GCD;
						end else begin
							mult_q  <= VAL_W'(1);
							state_q <= S_DONE;
						end
					end
				end
				S_GCD: begin
					if (div_rsp.done) begin
						if (div_rsp.rem != '0) begin
							// advance Euclid
							gy_q      <= div_rsp.rem;
							div_go_q  <= 1'b1;
							div_num_q <= gy_q;
							div_den_q <= div_rsp.rem;
						end else if (gy_q == MOD_W'(1)) begin
							mult_q  <= ga_q[VAL_W-1:0];
							state_q <= S_DONE;
						end else if (ga_inc < mod_w) begin
							ga_q      <= ga_inc;
							gy_q      <= ga_inc;
							div_go_q  <= 1'b1;
							div_num_q <= mod_w;
							div_den_q <= ga_inc;
						end else begin
							mult_q  <= VAL_W'(1);
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_q.value       <= cur_q;
			out_q.multiplier  <= mult_q;
			out_q.full_period <= fp_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

FILE: sv/lcg_chk.sv
// Port-level checker for the LCG top level, attached by the bind at the end.
// Depends on lcg_pkg for the item types.
module lcg_chk (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input lcg_pkg::out_item_t      out_item
);
	import lcg_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("output item changed while stalled");

	// an accepted item occupies the block
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block ready right after accepting an item");

	// the multiplier is never zero
	a_mult_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.multiplier != '0)
		else $error("zero multiplier in result");

	// a full-period multiplier is at least two
	a_fp_mult: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.full_period |-> out_item.multiplier > VAL_W'(1))
		else $error("full period flagged with multiplier below two");

endmodule

bind lcg_with_hull_dobell_params lcg_chk u_chk (.*);
